// ----- src/bffa_pkg.sv -----
// bffa_pkg: shared types and constants of the bitmap first-fit block allocator
// no dependencies; used by every module under src

package bffa_pkg;

  localparam int WORD_W     = 64;
  localparam int WORD_SHIFT = 6;
  localparam int BLK_W      = 12;
  localparam int WIDX_W     = BLK_W - WORD_SHIFT;
  localparam int OFF_W      = WORD_SHIFT + 1;

  localparam int SIZE_W     = 23;
  localparam int FIRST_W    = 10;
  localparam int COUNT_W    = 11;
  localparam int START_W    = 10;
  localparam int ADDR_W     = 49;
  localparam int BASE_W     = 48;
  localparam int BIU_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 48;
  localparam int NEED_W     = SIZE_W + 1;

  localparam logic [BIU_W-1:0] BIU_RESET = 11'd1024;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE     = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_SPACE = 2'd1,
    STAT_RANGE    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic             found;
    logic [BLK_W-1:0] start;
    logic [BLK_W-1:0] carry;
  } run_hit_t;

endpackage

// ----- src/bffa_map_ram.sv -----
// bffa_map_ram: used-bit map storage, one write port and one registered read port
// depends on bffa_pkg for the word width

module bffa_map_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [bffa_pkg::WORD_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [bffa_pkg::WORD_W-1:0] rdata
);
  import bffa_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/bffa_run_finder.sv -----
// bffa_run_finder: finds the lowest free run of a given length ending in one map word
// depends on bffa_pkg for widths and the run_hit_t result type

module bffa_run_finder (
  input  logic [bffa_pkg::WORD_W-1:0] data,
  input  logic [bffa_pkg::BLK_W-1:0]  g0,
  input  logic [bffa_pkg::BLK_W-1:0]  n,
  input  logic [bffa_pkg::BLK_W-1:0]  need,
  input  logic [bffa_pkg::BLK_W-1:0]  carry_in,
  output bffa_pkg::run_hit_t           hit_out
);
  import bffa_pkg::*;

  logic [WORD_W-1:0] used_eff;
  logic [WORD_W-1:0] hit;
  logic [WORD_W-1:0] lvl_v   [WORD_SHIFT+1];
  logic [BLK_W-1:0]  lvl_val [WORD_SHIFT+1][WORD_W];
  logic [WORD_SHIFT-1:0] pos;

  always_comb begin
    logic [BLK_W-1:0] g;
    logic [BLK_W-1:0] st;
    for (int j = 0; j < WORD_W; j++) begin
      g = g0 + BLK_W'(j);
      used_eff[j] = data[j] | (g >= n);
      lvl_v[0][j] = used_eff[j];
      lvl_val[0][j] = g + BLK_W'(1);
    end
    // prefix search for the most recent used block
    for (int l = 0; l < WORD_SHIFT; l++) begin
      for (int j = 0; j < WORD_W; j++) begin
        if (!lvl_v[l][j] && (j >= (1 << l))) begin
          lvl_v[l+1][j] = lvl_v[l][j - (1 << l)];
          lvl_val[l+1][j] = lvl_val[l][j - (1 << l)];
        end else begin
          lvl_v[l+1][j] = lvl_v[l][j];
          lvl_val[l+1][j] = lvl_val[l][j];
        end
      end
    end
    for (int j = 0; j < WORD_W; j++) begin
      g = g0 + BLK_W'(j);
      st = lvl_v[WORD_SHIFT][j] ? lvl_val[WORD_SHIFT][j] : carry_in;
      hit[j] = !used_eff[j] &&
               (({1'b0, st} + {1'b0, need}) <= {1'b0, g + BLK_W'(1)});
    end
    pos = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (hit[j]) begin
        pos = WORD_SHIFT'(j);
      end
    end
    hit_out.found = |hit;
    hit_out.start = g0 + BLK_W'(pos) + BLK_W'(1) - need;
    hit_out.carry = lvl_v[WORD_SHIFT][WORD_W-1] ? lvl_val[WORD_SHIFT][WORD_W-1] : carry_in;
  end

endmodule

// ----- src/bffa_run_mask.sv -----
// bffa_run_mask: bit mask of one map word covered by a block range [lo, hi)
// depends on bffa_pkg for widths

module bffa_run_mask (
  input  logic [bffa_pkg::BLK_W-1:0]  g0,
  input  logic [bffa_pkg::BLK_W-1:0]  lo,
  input  logic [bffa_pkg::BLK_W-1:0]  hi,
  output logic [bffa_pkg::WORD_W-1:0] mask
);
  import bffa_pkg::*;

  logic [OFF_W-1:0] lo_off;
  logic [OFF_W-1:0] hi_off;

  function automatic logic [OFF_W-1:0] clamp_off(input logic [BLK_W-1:0] v,
                                                 input logic [BLK_W-1:0] base);
    logic [BLK_W-1:0] diff;
    diff = v - base;
    if (v <= base) begin
      return '0;
    end else if (diff >= BLK_W'(WORD_W)) begin
      return OFF_W'(WORD_W);
    end else begin
      return diff[OFF_W-1:0];
    end
  endfunction

  always_comb begin
    lo_off = clamp_off(lo, g0);
    hi_off = clamp_off(hi, g0);
    for (int j = 0; j < WORD_W; j++) begin
      mask[j] = (OFF_W'(j) >= lo_off) && (OFF_W'(j) < hi_off);
    end
  end

endmodule

// ----- src/bitmap_first_fit_block_allocator.sv -----
// bitmap_first_fit_block_allocator: top level, control sequencer and output register
// depends on bffa_pkg, bffa_map_ram, bffa_run_finder and bffa_run_mask
//
// usage: one request word on the input channel (opcode, size_bytes, first_block,
// free_count) gives one result word on the output channel (status, alloc_block,
// block_address). both channels move a word when valid is high and stall is low.
// an allocate rounds size_bytes up to blocks and reserves the lowest free run in
// the pool; a free releases the given run. the used-bit map sits in one memory
// of 64-bit words with a registered read port.
// sequence: zero-size, oversize and out-of-pool requests go from idle straight
// to the response state once they are taken; an allocate scans map words, then
// marks the words of the found run, a refused one only scans, and a free clears
// the words of its run. the next request is taken in the cycle after the result
// is loaded. the map memory is worked one word at a time; one request is in work at a time.
// after reset the map is cleared one word a cycle with in_stall high;
// configuration writes are taken throughout.
// a finished result waits in the output register while out_stall is high and
// the next request is still taken; a second result waits until the first leaves.

module bitmap_first_fit_block_allocator #(
  parameter int MAX_BLOCKS  = 1024,
  parameter int BLOCK_SHIFT = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [bffa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bffa_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               opcode,
  input  logic [bffa_pkg::SIZE_W-1:0]        size_bytes,
  input  logic [bffa_pkg::FIRST_W-1:0]       first_block,
  input  logic [bffa_pkg::COUNT_W-1:0]       free_count,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         status,
  output logic [bffa_pkg::START_W-1:0]       alloc_block,
  output logic [bffa_pkg::ADDR_W-1:0]        block_address
);
  import bffa_pkg::*;

  localparam int MAP_WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam logic [NEED_W-1:0] ROUND = NEED_W'((1 << BLOCK_SHIFT) - 1);

  state_t state, state_next;
  logic [AW-1:0]     clr_cnt, clr_cnt_next;
  logic [WIDX_W-1:0] rd_word, rd_word_next;
  logic [WIDX_W-1:0] ev_word, ev_word_next;
  logic [WIDX_W-1:0] last_word, last_word_next;
  logic              rd_pend, rd_pend_next;
  logic [BLK_W-1:0]  carry, carry_next;
  logic [BLK_W-1:0]  need, need_next;
  logic [BLK_W-1:0]  lo, lo_next;
  logic [BLK_W-1:0]  hi, hi_next;
  logic              set_val, set_val_next;
  status_t           res_status, res_status_next;
  logic [BLK_W-1:0]  res_start, res_start_next;
  logic              res_addr_en, res_addr_en_next;

  logic [BIU_W-1:0]  blocks_in_use;
  logic [BASE_W-1:0] pool_base_address;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  logic [BLK_W-1:0]  n;
  logic [BLK_W-1:0]  g0;
  logic [NEED_W-1:0] need_in;
  logic [BLK_W-1:0]  free_end;
  logic [BLK_W-1:0]  n_last;
  logic [BLK_W-1:0]  run_end;
  logic [BLK_W-1:0]  free_last;
  logic [WORD_W-1:0] mask;
  run_hit_t          hit;
  logic              in_accept;
  logic              out_take;
  logic              out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_in_use     <= BIU_RESET;
      pool_base_address <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLOCKS_IN_USE: blocks_in_use <= cfg_data[BIU_W-1:0];
        REG_POOL_BASE:     pool_base_address <= cfg_data[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  assign n = (32'(blocks_in_use) < MAX_BLOCKS) ? BLK_W'(blocks_in_use) : BLK_W'(MAX_BLOCKS);
  assign need_in   = ({1'b0, size_bytes} + ROUND) >> BLOCK_SHIFT;
  assign free_end  = BLK_W'(first_block) + BLK_W'(free_count);
  assign free_last = free_end - BLK_W'(1);
  assign n_last    = n - BLK_W'(1);
  assign run_end   = hit.start + need - BLK_W'(1);
  assign g0        = {ev_word, {WORD_SHIFT{1'b0}}};

  bffa_map_ram #(
    .DEPTH(MAP_WORDS),
    .AW   (AW)
  ) u_map_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  bffa_run_finder u_run_finder (
    .data    (mem_rdata),
    .g0      (g0),
    .n       (n),
    .need    (need),
    .carry_in(carry),
    .hit_out (hit)
  );

  bffa_run_mask u_run_mask (
    .g0  (g0),
    .lo  (lo),
    .hi  (hi),
    .mask(mask)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_cnt   <= clr_cnt_next;
      rd_pend   <= rd_pend_next;
      out_valid <= out_load | (out_valid & ~out_take);
    end
  end

  always_ff @(posedge clk) begin
    rd_word     <= rd_word_next;
    ev_word     <= ev_word_next;
    last_word   <= last_word_next;
    carry       <= carry_next;
    need        <= need_next;
    lo          <= lo_next;
    hi          <= hi_next;
    set_val     <= set_val_next;
    res_status  <= res_status_next;
    res_start   <= res_start_next;
    res_addr_en <= res_addr_en_next;
    if (out_load) begin
      status        <= res_status;
      alloc_block   <= res_start[START_W-1:0];
      block_address <= res_addr_en ?
                       ({1'b0, pool_base_address} + (ADDR_W'(res_start) << BLOCK_SHIFT)) :
                       '0;
    end
  end

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid & ~in_stall;
  assign out_take  = out_valid & ~out_stall;

  always_comb begin
    state_next       = state;
    clr_cnt_next     = clr_cnt;
    rd_word_next     = rd_word;
    ev_word_next     = ev_word;
    last_word_next   = last_word;
    rd_pend_next     = rd_pend;
    carry_next       = carry;
    need_next        = need;
    lo_next          = lo;
    hi_next          = hi;
    set_val_next     = set_val;
    res_status_next  = res_status;
    res_start_next   = res_start;
    res_addr_en_next = res_addr_en;
    mem_we           = 1'b0;
    mem_waddr        = AW'(ev_word);
    mem_wdata        = set_val ? (mem_rdata | mask) : (mem_rdata & ~mask);
    mem_raddr        = AW'(rd_word);
    out_load         = 1'b0;

    case (state)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_cnt;
        mem_wdata    = '0;
        clr_cnt_next = clr_cnt + AW'(1);
        if (clr_cnt == AW'(MAP_WORDS - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_accept) begin
          res_start_next   = '0;
          res_addr_en_next = 1'b0;
          rd_pend_next     = 1'b0;
          carry_next       = '0;
          if (opcode == OP_ALLOC) begin
            if (need_in == '0) begin
              res_status_next  = STAT_OK;
              res_addr_en_next = 1'b1;
              state_next       = ST_RESP;
            end else if (need_in > NEED_W'(n)) begin
              res_status_next = STAT_NO_SPACE;
              state_next      = ST_RESP;
            end else begin
              need_next      = need_in[BLK_W-1:0];
              rd_word_next   = '0;
              last_word_next = n_last[BLK_W-1:WORD_SHIFT];
              state_next     = ST_SCAN;
            end
          end else begin
            if (free_end > n) begin
              res_status_next = STAT_RANGE;
              state_next      = ST_RESP;
            end else if (free_count == '0) begin
              res_status_next = STAT_OK;
              state_next      = ST_RESP;
            end else begin
              res_status_next = STAT_OK;
              lo_next         = BLK_W'(first_block);
              hi_next         = free_end;
              set_val_next    = 1'b0;
              rd_word_next    = WIDX_W'(first_block >> WORD_SHIFT);
              last_word_next  = free_last[BLK_W-1:WORD_SHIFT];
              state_next      = ST_UPDATE;
            end
          end
        end
      end

      ST_SCAN: begin
        rd_pend_next = (rd_word <= last_word);
        ev_word_next = rd_word;
        rd_word_next = rd_word + WIDX_W'(1);
        if (rd_pend) begin
          carry_next = hit.carry;
          if (hit.found) begin
            res_status_next  = STAT_OK;
            res_start_next   = hit.start;
            res_addr_en_next = 1'b1;
            lo_next          = hit.start;
            hi_next          = hit.start + need;
            set_val_next     = 1'b1;
            rd_word_next     = hit.start[BLK_W-1:WORD_SHIFT];
            last_word_next   = run_end[BLK_W-1:WORD_SHIFT];
            rd_pend_next     = 1'b0;
            state_next       = ST_UPDATE;
          end else if (ev_word == last_word) begin
            res_status_next = STAT_NO_SPACE;
            rd_pend_next    = 1'b0;
            state_next      = ST_RESP;
          end
        end
      end

      ST_UPDATE: begin
        rd_pend_next = (rd_word <= last_word);
        ev_word_next = rd_word;
        rd_word_next = rd_word + WIDX_W'(1);
        if (rd_pend) begin
          mem_we = 1'b1;
          if (ev_word == last_word) begin
            rd_pend_next = 1'b0;
            state_next   = ST_RESP;
          end
        end
      end

      ST_RESP: begin
        if (!out_valid || out_take) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- dv/bffa_checker.sv -----
// bffa_checker: watches the request, result and register ports of the allocator,
// keeps its own used-block map and compares every result word in order
// depends on bffa_pkg

module bffa_checker #(
  parameter int MAX_BLOCKS  = 1024,
  parameter int BLOCK_SHIFT = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bffa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bffa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            opcode,
  input  logic [bffa_pkg::SIZE_W-1:0]     size_bytes,
  input  logic [bffa_pkg::FIRST_W-1:0]    first_block,
  input  logic [bffa_pkg::COUNT_W-1:0]    free_count,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [1:0]                      status,
  input  logic [bffa_pkg::START_W-1:0]    alloc_block,
  input  logic [bffa_pkg::ADDR_W-1:0]     block_address,
  output int                              errors,
  output int                              pending,
  output int                              n_placed,
  output int                              n_refused,
  output int                              n_freed,
  output int                              n_range
);
  timeunit 1ns;
  timeprecision 1ps;
  import bffa_pkg::*;

  typedef struct packed {
    logic                op;
    status_t             st;
    logic [START_W-1:0]  start;
    logic [ADDR_W-1:0]   addr;
  } placement_t;

  logic [MAX_BLOCKS-1:0] used_map;
  logic [BIU_W-1:0]      pool_limit;
  logic [BASE_W-1:0]     pool_base;
  placement_t            awaited_placements[$];

  function automatic placement_t predict_placement(input logic op,
                                                   input logic [SIZE_W-1:0] size,
                                                   input logic [FIRST_W-1:0] first,
                                                   input logic [COUNT_W-1:0] count);
    placement_t r;
    int pool, need, run, s, i;
    bit found;
    r.op    = op;
    r.st    = STAT_OK;
    r.start = '0;
    r.addr  = '0;
    pool = (int'(pool_limit) < MAX_BLOCKS) ? int'(pool_limit) : MAX_BLOCKS;
    if (op == OP_ALLOC) begin
      need = (int'(size) + (1 << BLOCK_SHIFT) - 1) >> BLOCK_SHIFT;
      if (need == 0) begin
        r.addr = ADDR_W'(pool_base);
      end else if (need > pool) begin
        r.st = STAT_NO_SPACE;
      end else begin
        run   = 0;
        s     = 0;
        found = 1'b0;
        for (i = 0; i < pool && !found; i++) begin
          if (used_map[i]) begin
            run = 0;
          end else begin
            run++;
            if (run == need) begin
              s     = i + 1 - run;
              found = 1'b1;
            end
          end
        end
        if (!found) begin
          r.st = STAT_NO_SPACE;
        end else begin
          for (i = 0; i < need; i++) used_map[s + i] = 1'b1;
          r.start = START_W'(s);
          r.addr  = ADDR_W'(pool_base) + (ADDR_W'(s) << BLOCK_SHIFT);
        end
      end
    end else begin
      if (int'(first) + int'(count) > pool) begin
        r.st = STAT_RANGE;
      end else begin
        for (i = 0; i < int'(count); i++) used_map[int'(first) + i] = 1'b0;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    placement_t want;
    if (rst) begin
      used_map   = '0;
      pool_limit = BIU_RESET;
      pool_base  = '0;
      awaited_placements.delete();
      errors    = 0;
      n_placed  = 0;
      n_refused = 0;
      n_freed   = 0;
      n_range   = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_BLOCKS_IN_USE) pool_limit = BIU_W'(cfg_data);
        else if (cfg_index == REG_POOL_BASE) pool_base = BASE_W'(cfg_data);
      end
      if (in_valid && !in_stall)
        awaited_placements.push_back(predict_placement(opcode, size_bytes, first_block,
                                                       free_count));
      if (out_valid && !out_stall) begin
        if (awaited_placements.size() == 0) begin
          errors++;
          $display("%0t: result word with nothing awaited: status %0d block %0d addr 0x%0h",
                   $time, status, alloc_block, block_address);
        end else begin
          want = awaited_placements.pop_front();
          if (status !== want.st) begin
            errors++;
            $display("%0t: status expected %0d got %0d", $time, want.st, status);
          end
          if (alloc_block !== want.start) begin
            errors++;
            $display("%0t: alloc_block expected %0d got %0d", $time, want.start, alloc_block);
          end
          if (block_address !== want.addr) begin
            errors++;
            $display("%0t: block_address expected 0x%0h got 0x%0h", $time, want.addr,
                     block_address);
          end
          case (want.st)
            STAT_OK:       if (want.op == OP_ALLOC) n_placed++; else n_freed++;
            STAT_NO_SPACE: n_refused++;
            default:       n_range++;
          endcase
        end
      end
    end
    pending = awaited_placements.size();
  end

endmodule

// ----- dv/tb.sv -----
// tb: drives allocate and free words into the allocator under several pool
// settings and idle patterns; checking is done by bffa_checker
// depends on bffa_pkg, bffa_checker and bitmap_first_fit_block_allocator

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bffa_pkg::*;

  localparam int MAX_BLOCKS  = 1024;
  localparam int BLOCK_SHIFT = 12;
  localparam int BLOCK_BYTES = 1 << BLOCK_SHIFT;
  localparam int QUIET_LIMIT = 5000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_BLOCKS_IN_USE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  opcode = OP_ALLOC;
  logic [SIZE_W-1:0]     size_bytes = '0;
  logic [FIRST_W-1:0]    first_block = '0;
  logic [COUNT_W-1:0]    free_count = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            status;
  logic [START_W-1:0]    alloc_block;
  logic [ADDR_W-1:0]     block_address;

  int errors, pending, n_placed, n_refused, n_freed, n_range;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int cur_pool = MAX_BLOCKS;
  int quiet_cycles = 0;

  bitmap_first_fit_block_allocator #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .BLOCK_SHIFT(BLOCK_SHIFT)
  ) dut (.*);

  bffa_checker #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .BLOCK_SHIFT(BLOCK_SHIFT)
  ) alloc_check (.*);

  always #1ns clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no word moved for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, pending);
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic op, input logic [SIZE_W-1:0] size,
                           input logic [FIRST_W-1:0] first, input logic [COUNT_W-1:0] count);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    size_bytes  <= size;
    first_block <= first;
    free_count  <= count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_config(input int blocks, input logic [BASE_W-1:0] base);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BLOCKS_IN_USE;
    cfg_data  <= CFG_DATA_W'(blocks);
    @(negedge clk);
    cfg_index <= REG_POOL_BASE;
    cfg_data  <= CFG_DATA_W'(base);
    @(negedge clk);
    cfg_we   <= 1'b0;
    cur_pool = (blocks < MAX_BLOCKS) ? blocks : MAX_BLOCKS;
  endtask

  task automatic rand_word();
    int roll, blocks, pool_hi;
    logic [SIZE_W-1:0]  size;
    logic [FIRST_W-1:0] first;
    logic [COUNT_W-1:0] count;
    pool_hi = (cur_pool > 0) ? cur_pool : 1;
    size    = SIZE_W'($urandom);
    first   = FIRST_W'($urandom);
    count   = COUNT_W'($urandom);
    roll    = $urandom_range(99);
    if (roll < 48) begin
      roll   = $urandom_range(99);
      blocks = 1;
      if (roll < 60) blocks = $urandom_range(1, 8);
      else if (roll < 75) blocks = $urandom_range(1, 64);
      else if (roll < 85) blocks = $urandom_range(1, pool_hi);
      if (roll < 85) size = SIZE_W'((blocks - 1) * BLOCK_BYTES + $urandom_range(1, BLOCK_BYTES));
      else if (roll < 93) size = SIZE_W'($urandom_range(0, 8) * BLOCK_BYTES);
      send_word(OP_ALLOC, size, first, count);
    end else if (roll < 51) begin
      send_word(OP_FREE, size, '0, COUNT_W'(cur_pool));
    end else begin
      roll = $urandom_range(99);
      if (roll < 92) first = FIRST_W'($urandom_range(0, pool_hi - 1));
      if (roll < 80) count = COUNT_W'($urandom_range(1, 16));
      else if (roll < 85) count = '0;
      else if (roll < 89) count = COUNT_W'(cur_pool - int'(first));
      else if (roll < 92) count = COUNT_W'(cur_pool - int'(first) + 1);
      send_word(OP_FREE, size, first, count);
    end
  endtask

  task automatic run_random(input int n, input int idle_pct, input int hold_pct);
    sender_idle_pct = idle_pct;
    stall_pct       = hold_pct;
    repeat (n) rand_word();
    drain();
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // reset settings: full pool at base 0
    send_word(OP_ALLOC, '0, '0, '0);
    send_word(OP_ALLOC, SIZE_W'(1), '0, '0);
    send_word(OP_ALLOC, SIZE_W'(BLOCK_BYTES), '0, '0);
    send_word(OP_ALLOC, SIZE_W'(BLOCK_BYTES + 1), '0, '0);
    send_word(OP_ALLOC, '1, '0, '0);
    send_word(OP_ALLOC, SIZE_W'(MAX_BLOCKS * BLOCK_BYTES), '0, '0);
    send_word(OP_FREE, '0, FIRST_W'(1023), COUNT_W'(1));
    send_word(OP_FREE, '0, FIRST_W'(1023), COUNT_W'(2));
    send_word(OP_FREE, '0, '0, '1);
    send_word(OP_FREE, '0, FIRST_W'(1), '0);
    send_word(OP_FREE, '0, FIRST_W'(500), COUNT_W'(10));
    send_word(OP_FREE, '0, '0, COUNT_W'(MAX_BLOCKS));
    send_word(OP_ALLOC, SIZE_W'(MAX_BLOCKS * BLOCK_BYTES), '0, '0);
    send_word(OP_ALLOC, '0, '0, '0);
    send_word(OP_ALLOC, SIZE_W'(1), '0, '0);
    send_word(OP_FREE, '0, FIRST_W'(512), COUNT_W'(3));
    send_word(OP_ALLOC, SIZE_W'(3 * BLOCK_BYTES), '0, '0);
    send_word(OP_FREE, '0, FIRST_W'(512), COUNT_W'(1));
    send_word(OP_ALLOC, SIZE_W'(2 * BLOCK_BYTES), '0, '0);
    send_word(OP_ALLOC, SIZE_W'(BLOCK_BYTES), '0, '0);
    send_word(OP_FREE, '0, '0, COUNT_W'(MAX_BLOCKS));
    drain();

    run_random(350, 0, 0);
    write_config(2047, '1);
    run_random(300, 77, 0);
    write_config(64, BASE_W'({$urandom, $urandom}));
    run_random(300, 0, 77);
    write_config(1, BASE_W'(48'h1000));
    run_random(150, 22, 22);

    // empty pool
    write_config(0, '1);
    send_word(OP_ALLOC, '0, '0, '0);
    send_word(OP_ALLOC, SIZE_W'(1), '0, '0);
    send_word(OP_FREE, '0, '0, '0);
    send_word(OP_FREE, '0, FIRST_W'(1023), '0);
    send_word(OP_FREE, '0, '0, COUNT_W'(1));
    run_random(40, 22, 22);

    write_config($urandom_range(1, MAX_BLOCKS), BASE_W'({$urandom, $urandom}));
    run_random(350, 22, 22);
    write_config(MAX_BLOCKS, BASE_W'({$urandom, $urandom}));
    run_random(210, 0, 0);

    drain();
    repeat (64) @(negedge clk);
    $display("checked %0d placements, %0d refusals for space, %0d frees, %0d frees past the pool",
             n_placed, n_refused, n_freed, n_range);
    $display("pools of 0 to 2047 blocks, bases from zero to all ones, with and without idling");
    if (errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule
